// ===== src/icoc_pkg.sv =====
// ----------------------------------------------------------------------------
// icoc_pkg
// Types and codes shared by the interval clock and option controller.
// ----------------------------------------------------------------------------
package icoc_pkg;

  localparam int WORD_W    = 16;
  localparam int ELAPSED_W = 22;

  // transaction kinds
  localparam logic [2:0] KIND_READ  = 3'd0;
  localparam logic [2:0] KIND_WRITE = 3'd1;
  localparam logic [2:0] KIND_PULSE = 3'd2;
  localparam logic [2:0] KIND_SKIP  = 3'd3;
  localparam logic [2:0] KIND_TICK  = 3'd4;

  // read function codes
  localparam logic [3:0] RD_INTERVAL = 4'o02;
  localparam logic [3:0] RD_ID       = 4'o11;
  localparam logic [3:0] RD_CELL     = 4'o12;
  localparam logic [3:0] RD_VECTOR   = 4'o13;
  localparam logic [3:0] RD_SENSE    = 4'o16;
  localparam logic [3:0] RD_DATA_SW  = 4'o17;

  // write function codes
  localparam logic [3:0] WR_INTERVAL = 4'o02;
  localparam logic [3:0] WR_CONTROL  = 4'o07;
  localparam logic [3:0] WR_CELL     = 4'o12;
  localparam logic [3:0] WR_VECTOR   = 4'o13;
  localparam logic [3:0] WR_LIGHTS   = 4'o17;

  // control pulse function codes
  localparam logic [3:0] PL_ACK_INC0 = 4'o00;
  localparam logic [3:0] PL_ACK      = 4'o01;
  localparam logic [3:0] PL_ACK_INC2 = 4'o02;
  localparam logic [3:0] PL_NOP_LO   = 4'o04;
  localparam logic [3:0] PL_NOP_HI   = 4'o07;
  localparam logic [3:0] PL_MASK_SET = 4'o15;
  localparam logic [3:0] PL_MASK_CLR = 4'o16;
  localparam logic [3:0] PL_RESET    = 4'o17;

  localparam logic [3:0] SKIP_TEST   = 4'o00;

  localparam logic [WORD_W-1:0] DEVICE_ID_RESET = 16'd80;

  typedef struct packed {
    logic [2:0]        kind;
    logic [3:0]        func;
    logic [WORD_W-1:0] write_data;
    logic [WORD_W-1:0] cell_word;
    logic [WORD_W-1:0] sense_switches;
    logic [WORD_W-1:0] data_switches;
  } req_t;

  typedef struct packed {
    logic [WORD_W-1:0] read_data;
    logic              skip;
    logic              cell_store;
    logic [WORD_W-1:0] cell_address;
    logic [WORD_W-1:0] cell_value;
    logic              irq_pending;
    logic [WORD_W-1:0] irq_vector;
    logic [WORD_W-1:0] lights;
    logic              unsupported;
  } rsp_t;

endpackage

// ===== src/icoc_stream.sv =====
// ----------------------------------------------------------------------------
// icoc_stream
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface icoc_stream #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/interval_clock_option_controller.sv =====
// A result is registered in the result register, or in the skid entry while
//   rsp stalls. Throughput: one request per cycle while the skid entry is
//   empty, so a request is taken while a result waits on the response side.
// Reset (rst, synchronous): all option registers, the interrupt, the mask and
//   the tick count clear; device_id returns to 80; both result slots empty.
// ----------------------------------------------------------------------------
// interval_clock_option_controller
// Option register file, interval clock and interrupt logic, one pass per
// request transaction.
// ----------------------------------------------------------------------------
module interval_clock_option_controller #(
  parameter int ACTIVE_BIT    = 15,
  parameter int INCREMENT_BIT = 14,
  parameter int SLOW_BIT      = 13,
  parameter int SLOW_SHIFT    = 5
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [icoc_pkg::WORD_W-1:0] cfg_wr_data,
  icoc_stream.sink                  req,
  icoc_stream.source                rsp
);
  import icoc_pkg::*;

  localparam int PERIOD_W = WORD_W + 1 + SLOW_SHIFT;
  localparam int CMP_W    = (PERIOD_W > ELAPSED_W) ? PERIOD_W : ELAPSED_W;

  logic [WORD_W-1:0]    device_id;
  logic [WORD_W-1:0]    interval_reg, interval_next;
  logic [WORD_W-1:0]    control_reg, control_next;
  logic [WORD_W-1:0]    cell_addr_reg, cell_addr_next;
  logic [WORD_W-1:0]    vector_reg, vector_next;
  logic [WORD_W-1:0]    lights_reg, lights_next;
  logic                 mask_bit, mask_next;
  logic                 pending_bit, pending_next;
  logic [ELAPSED_W-1:0] elapsed_ticks, elapsed_next;

  rsp_t result;
  rsp_t out_data, skid_data;
  logic out_valid, skid_valid;

  logic                 accept;
  logic [WORD_W:0]      base_period;
  logic [PERIOD_W-1:0]  period;
  logic [ELAPSED_W-1:0] elapsed_inc;
  logic                 expired;
  logic [WORD_W-1:0]    cell_inc;
  req_t                 r;

  assign r      = req.payload;
  assign accept = req.valid && req.ready;

  // period is recomputed from the live registers on every tick
  assign base_period = {1'b1, {WORD_W{1'b0}}} - {1'b0, interval_reg};
  assign period      = control_reg[SLOW_BIT]
                     ? ({{SLOW_SHIFT{1'b0}}, base_period} << SLOW_SHIFT)
                     : {{SLOW_SHIFT{1'b0}}, base_period};
  assign elapsed_inc = elapsed_ticks + ELAPSED_W'(1);
  assign expired     = CMP_W'(elapsed_inc) >= CMP_W'(period);
  assign cell_inc    = r.cell_word + WORD_W'(1);

  always_comb begin
    interval_next  = interval_reg;
    control_next   = control_reg;
    cell_addr_next = cell_addr_reg;
    vector_next    = vector_reg;
    lights_next    = lights_reg;
    mask_next      = mask_bit;
    pending_next   = pending_bit;
    elapsed_next   = elapsed_ticks;

    result              = '0;
    case (r.kind)
      KIND_READ: begin
        case (r.func)
          RD_INTERVAL: result.read_data = interval_reg;
          RD_ID:       result.read_data = device_id;
          RD_CELL:     result.read_data = cell_addr_reg;
          RD_VECTOR:   result.read_data = vector_reg;
          RD_SENSE:    result.read_data = r.sense_switches;
          RD_DATA_SW:  result.read_data = r.data_switches;
          default:     result.unsupported = 1'b1;
        endcase
      end
      KIND_WRITE: begin
        case (r.func)
          WR_INTERVAL: interval_next = r.write_data;
          WR_CONTROL:  control_next = r.write_data;
          WR_CELL:     cell_addr_next = r.write_data;
          WR_VECTOR: begin
            vector_next = r.write_data;
            mask_next   = 1'b1;
          end
          WR_LIGHTS:   lights_next = r.write_data;
          default:     result.unsupported = 1'b1;
        endcase
      end
      KIND_PULSE: begin
        if (r.func == PL_ACK_INC0 || r.func == PL_ACK_INC2) begin
          pending_next                = 1'b0;
          control_next[INCREMENT_BIT] = 1'b1;
        end else if (r.func == PL_ACK) begin
          pending_next = 1'b0;
        end else if (r.func inside {[PL_NOP_LO:PL_NOP_HI]}) begin
          // accepted, no effect
        end else if (r.func == PL_MASK_SET) begin
          mask_next = 1'b1;
        end else if (r.func == PL_MASK_CLR) begin
          mask_next = 1'b0;
        end else if (r.func == PL_RESET) begin
          mask_next    = 1'b0;
          control_next = '0;
        end else begin
          result.unsupported = 1'b1;
        end
      end
      KIND_SKIP: begin
        if (r.func == SKIP_TEST) begin
          result.skip = !pending_bit;
        end else begin
          result.unsupported = 1'b1;
        end
      end
      KIND_TICK: begin
        elapsed_next = elapsed_inc;
        if (expired) begin
          elapsed_next = '0;
          if (control_reg[ACTIVE_BIT] && control_reg[INCREMENT_BIT]) begin
            if (cell_addr_reg != '0) begin
              if (cell_inc == '0 && mask_bit) begin
                pending_next = 1'b1;
              end
              result.cell_store   = 1'b1;
              result.cell_address = cell_addr_reg;
              result.cell_value   = cell_inc;
            end
          end else if (control_reg[ACTIVE_BIT] && mask_bit) begin
            pending_next = 1'b1;
          end
        end
      end
      default: result.unsupported = 1'b1;
    endcase

    result.irq_pending = pending_next;
    result.irq_vector  = vector_next;
    result.lights      = lights_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      device_id     <= DEVICE_ID_RESET;
      interval_reg  <= '0;
      control_reg   <= '0;
      cell_addr_reg <= '0;
      vector_reg    <= '0;
      lights_reg    <= '0;
      mask_bit      <= 1'b0;
      pending_bit   <= 1'b0;
      elapsed_ticks <= '0;
    end else begin
      if (cfg_wr_en) begin
        device_id <= cfg_wr_data;
      end
      if (accept) begin
        interval_reg  <= interval_next;
        control_reg   <= control_next;
        cell_addr_reg <= cell_addr_next;
        vector_reg    <= vector_next;
        lights_reg    <= lights_next;
        mask_bit      <= mask_next;
        pending_bit   <= pending_next;
        elapsed_ticks <= elapsed_next;
      end
    end
  end

  // result register with one skid entry behind it
  assign req.ready   = !skid_valid;
  assign rsp.valid   = out_valid;
  assign rsp.payload = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (rsp.ready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp.ready || !out_valid) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (accept) begin
        out_data <= result;
      end
    end else if (accept) begin
      skid_data <= result;
    end
  end

endmodule

// ===== src/icoc_checker.sv =====
// ----------------------------------------------------------------------------
// icoc_checker
// Port-level checks on the option controller's response channel.
// ----------------------------------------------------------------------------
module icoc_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        rsp_valid,
  input logic                        rsp_ready,
  input icoc_pkg::rsp_t              rsp_payload
);
  import icoc_pkg::*;

  // nothing is presented in the cycle after reset
  assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

  // a stalled response holds
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
    else $error("stalled response changed");

  // a cell store always names a nonzero cell; no store leaves the fields clear
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_payload.cell_store ? rsp_payload.cell_address != '0
                   : (rsp_payload.cell_address == '0 && rsp_payload.cell_value == '0)))
    else $error("cell store fields inconsistent");

  // an unrecognized code returns no data, no skip and no store
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_payload.unsupported |->
      rsp_payload.read_data == '0 && !rsp_payload.skip && !rsp_payload.cell_store)
    else $error("unsupported code produced data");

  // skip only when no interrupt is pending
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_payload.skip |-> !rsp_payload.irq_pending && rsp_payload.read_data == '0)
    else $error("skip with interrupt pending");

endmodule

bind interval_clock_option_controller icoc_checker u_icoc_checker (
  .clk         (clk),
  .rst         (rst),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .rsp_payload (rsp.payload)
);

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the interval clock and option controller. A queue
// fed driver offers request transactions with random gaps (none in the last
// stretch), a monitor accepts responses with random stalls, and an in-bench
// predictor of the register file, interval clock and interrupt logic checks every response field.
// ----------------------------------------------------------------------------
module testbench;
  import icoc_pkg::*;

  localparam int CTL_ACTIVE  = 15;
  localparam int CTL_INC     = 14;
  localparam int CTL_SLOW    = 13;
  localparam int SLOW_SHIFT  = 5;
  localparam int CHUNK       = 640;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 80;

  // code that no kind of request recognizes, and a kind outside the range
  localparam logic [3:0] FN_UNUSED = 4'o03;
  localparam logic [2:0] KIND_BAD  = 3'd7;

  logic              clk;
  logic              rst;
  logic              cfg_wr_en;
  logic [WORD_W-1:0] cfg_wr_data;

  icoc_stream #(.T(req_t)) req_if ();
  icoc_stream #(.T(rsp_t)) rsp_if ();

  interval_clock_option_controller #(
    .ACTIVE_BIT   (CTL_ACTIVE),
    .INCREMENT_BIT(CTL_INC),
    .SLOW_BIT     (CTL_SLOW),
    .SLOW_SHIFT   (SLOW_SHIFT)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .req        (req_if),
    .rsp        (rsp_if)
  );

  // predicted controller state
  logic [WORD_W-1:0]    id_word;
  logic [WORD_W-1:0]    ivl_word;
  logic [WORD_W-1:0]    ctl_word;
  logic [WORD_W-1:0]    cell_ptr;
  logic [WORD_W-1:0]    vec_word;
  logic [WORD_W-1:0]    lamp_word;
  logic                 mask_on;
  logic                 irq_on;
  logic [ELAPSED_W-1:0] tick_count;

  req_t send_q[$];
  rsp_t want_q[$];

  int errors;
  int queued;
  int results_seen;
  int stores_seen;
  int irq_rises;
  int unsup_seen;
  int cycles;
  int send_gap;
  int recv_gap;
  int hold_left;
  bit idle_on;
  bit long_hold_done;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic rsp_t option_response(req_t r);
    logic [ELAPSED_W:0] span;
    logic [WORD_W-1:0]  bumped;
    rsp_t               o;
    o = '0;
    case (r.kind)
      KIND_READ: begin
        case (r.func)
          RD_INTERVAL: o.read_data = ivl_word;
          RD_ID:       o.read_data = id_word;
          RD_CELL:     o.read_data = cell_ptr;
          RD_VECTOR:   o.read_data = vec_word;
          RD_SENSE:    o.read_data = r.sense_switches;
          RD_DATA_SW:  o.read_data = r.data_switches;
          default:     o.unsupported = 1'b1;
        endcase
      end
      KIND_WRITE: begin
        case (r.func)
          WR_INTERVAL: ivl_word = r.write_data;
          WR_CONTROL:  ctl_word = r.write_data;
          WR_CELL:     cell_ptr = r.write_data;
          WR_VECTOR: begin
            vec_word = r.write_data;
            mask_on  = 1'b1;
          end
          WR_LIGHTS:   lamp_word = r.write_data;
          default:     o.unsupported = 1'b1;
        endcase
      end
      KIND_PULSE: begin
        case (r.func)
          PL_ACK_INC0, PL_ACK_INC2: begin
            irq_on            = 1'b0;
            ctl_word[CTL_INC] = 1'b1;
          end
          PL_ACK:      irq_on = 1'b0;
          PL_MASK_SET: mask_on = 1'b1;
          PL_MASK_CLR: mask_on = 1'b0;
          PL_RESET: begin
            // interrupt request survives the reset pulse
            mask_on  = 1'b0;
            ctl_word = '0;
          end
          default: begin
            if (r.func < PL_NOP_LO || r.func > PL_NOP_HI) o.unsupported = 1'b1;
          end
        endcase
      end
      KIND_SKIP: begin
        if (r.func == SKIP_TEST) o.skip = !irq_on;
        else o.unsupported = 1'b1;
      end
      KIND_TICK: begin
        // period follows the live register values, so a shortened period
        // expires as soon as the count is at or past it
        span = 23'h10000 - {7'd0, ivl_word};
        if (ctl_word[CTL_SLOW]) span = span << SLOW_SHIFT;
        tick_count = tick_count + 1'b1;
        if ({1'b0, tick_count} >= span) begin
          tick_count = '0;
          if (ctl_word[CTL_ACTIVE] && ctl_word[CTL_INC]) begin
            if (cell_ptr != '0) begin
              bumped = r.cell_word + 1'b1;
              if (bumped == '0 && mask_on) irq_on = 1'b1;
              o.cell_store   = 1'b1;
              o.cell_address = cell_ptr;
              o.cell_value   = bumped;
            end
          end else if (ctl_word[CTL_ACTIVE] && mask_on) begin
            irq_on = 1'b1;
          end
        end
      end
      default: o.unsupported = 1'b1;
    endcase
    o.irq_pending = irq_on;
    o.irq_vector  = vec_word;
    o.lights      = lamp_word;
    return o;
  endfunction

  task automatic report_error(input string msg);
    errors = errors + 1;
    $display("ERROR @%0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [WORD_W-1:0] got,
                             input logic [WORD_W-1:0] want);
    if (got !== want)
      report_error($sformatf("response %0d field %s: got %h, predicted %h",
                             results_seen, name, got, want));
  endtask

  function automatic logic [WORD_W-1:0] rand_word();
    return WORD_W'($urandom);
  endfunction

  task automatic queue_item(input logic [2:0] kind, input logic [3:0] func,
                            input logic [WORD_W-1:0] wdata,
                            input logic [WORD_W-1:0] cword);
    req_t r;
    r.kind           = kind;
    r.func           = func;
    r.write_data     = wdata;
    r.cell_word      = cword;
    r.sense_switches = rand_word();
    r.data_switches  = rand_word();
    send_q.push_back(r);
    queued = queued + 1;
  endtask

  function automatic logic [WORD_W-1:0] tick_word();
    logic [WORD_W-1:0] w;
    // all-ones often, so the cell wraps
    if ($urandom_range(0, 3) == 0) w = 16'hFFFF;
    else w = rand_word();
    return w;
  endfunction

  // one burst: a mostly well-formed clock setup followed by a run of mostly ticks
  task automatic add_scenario();
    logic [2:0]        k;
    logic [3:0]        f;
    logic [WORD_W-1:0] w;
    int                n;
    if ($urandom_range(0, 9) < 2) begin
      k = 3'($urandom_range(0, 7));
      f = 4'($urandom);
      queue_item(k, f, rand_word(), rand_word());
      return;
    end
    if ($urandom_range(0, 2) != 0) begin
      if ($urandom_range(0, 3) == 0) w = rand_word();
      else w = 16'hFFFF - WORD_W'($urandom_range(0, 6));
      queue_item(KIND_WRITE, WR_INTERVAL, w, rand_word());
    end
    if ($urandom_range(0, 2) != 0) begin
      w = rand_word();
      w[CTL_ACTIVE] = ($urandom_range(0, 4) != 0);
      w[CTL_SLOW]   = ($urandom_range(0, 3) == 0);
      queue_item(KIND_WRITE, WR_CONTROL, w, rand_word());
    end
    if ($urandom_range(0, 3) == 0) begin
      if ($urandom_range(0, 4) == 0) w = '0;
      else w = rand_word();
      queue_item(KIND_WRITE, WR_CELL, w, rand_word());
    end
    case ($urandom_range(0, 5))
      0: queue_item(KIND_WRITE, WR_VECTOR, rand_word(), rand_word());
      1: queue_item(KIND_PULSE, PL_MASK_SET, rand_word(), rand_word());
      2: queue_item(KIND_PULSE, PL_MASK_CLR, rand_word(), rand_word());
      default: ;
    endcase
    n = $urandom_range(3, 20);
    repeat (n) begin
      f = 4'($urandom);
      case ($urandom_range(0, 11))
        0: queue_item(KIND_SKIP, SKIP_TEST, rand_word(), rand_word());
        1: queue_item(KIND_PULSE, f, rand_word(), rand_word());
        2: queue_item(KIND_READ, f, rand_word(), rand_word());
        3: begin
          w = 16'hFFFF - WORD_W'($urandom_range(0, 40));
          queue_item(KIND_WRITE, WR_INTERVAL, w, rand_word());
        end
        default: queue_item(KIND_TICK, f, rand_word(), tick_word());
      endcase
    end
  endtask

  task automatic fill_random(input int count);
    int start;
    start = queued;
    while (queued - start < count) add_scenario();
  endtask

  task automatic wait_drained();
    while (send_q.size() != 0 || want_q.size() != 0) @(negedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_device_id(input logic [WORD_W-1:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    id_word = v;
    @(negedge clk);
  endtask

  // request driver
  always @(posedge clk) begin : drive_req
    req_t taken;
    rsp_t pred;
    logic was_irq;
    if (rst) begin
      req_if.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        taken   = send_q.pop_front();
        was_irq = irq_on;
        pred    = option_response(taken);
        want_q.push_back(pred);
        if (pred.cell_store) stores_seen = stores_seen + 1;
        if (pred.irq_pending && !was_irq) irq_rises = irq_rises + 1;
        if (pred.unsupported) unsup_seen = unsup_seen + 1;
        if (idle_on && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 11);
      end
      // a transaction on offer stays put until it is taken
      if (!(req_if.valid && !req_if.ready)) begin
        if (send_gap > 0) begin
          send_gap = send_gap - 1;
          req_if.valid <= 1'b0;
        end else if (send_q.size() > 0) begin
          req_if.valid   <= 1'b1;
          req_if.payload <= send_q[0];
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // one long hold early on so the request side backs up and stalls
  always @(posedge clk) begin : long_stall
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (!long_hold_done && results_seen >= 200) begin
      long_hold_done <= 1'b1;
      hold_left      <= HOLD_CYCLES;
    end
  end

  // response monitor and ready control
  always @(posedge clk) begin : watch_rsp
    rsp_t got;
    rsp_t want;
    if (rst) begin
      rsp_if.ready <= 1'b0;
      recv_gap  = 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        got = rsp_if.payload;
        results_seen = results_seen + 1;
        if (want_q.size() == 0) begin
          report_error($sformatf("response %0d with no request outstanding", results_seen));
        end else begin
          want = want_q.pop_front();
          check_field("read_data", got.read_data, want.read_data);
          check_field("skip", WORD_W'(got.skip), WORD_W'(want.skip));
          check_field("cell_store", WORD_W'(got.cell_store), WORD_W'(want.cell_store));
          check_field("cell_address", got.cell_address, want.cell_address);
          check_field("cell_value", got.cell_value, want.cell_value);
          check_field("irq_pending", WORD_W'(got.irq_pending), WORD_W'(want.irq_pending));
          check_field("irq_vector", got.irq_vector, want.irq_vector);
          check_field("lights", got.lights, want.lights);
          check_field("unsupported", WORD_W'(got.unsupported), WORD_W'(want.unsupported));
        end
      end
      if (hold_left > 0) begin
        rsp_if.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap = recv_gap - 1;
        rsp_if.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        recv_gap = $urandom_range(1, 11) - 1;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses outstanding", cycles, want_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    rst            = 1'b1;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    req_if.valid   = 1'b0;
    req_if.payload = '0;
    rsp_if.ready   = 1'b0;
    idle_on        = 1'b1;
    long_hold_done = 1'b0;
    errors         = 0;
    queued         = 0;
    results_seen   = 0;
    stores_seen    = 0;
    irq_rises      = 0;
    unsup_seen     = 0;
    cycles         = 0;
    id_word        = DEVICE_ID_RESET;
    ivl_word       = '0;
    ctl_word       = '0;
    cell_ptr       = '0;
    vec_word       = '0;
    lamp_word      = '0;
    mask_on        = 1'b0;
    irq_on         = 1'b0;
    tick_count     = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: reset values, unknown codes, a two-tick period walked
    // through the masked, interrupting and cell-increment paths
    queue_item(KIND_READ, RD_ID, '0, '0);
    queue_item(KIND_READ, RD_INTERVAL, '0, '0);
    queue_item(KIND_READ, RD_SENSE, '0, '0);
    queue_item(KIND_READ, RD_DATA_SW, '0, '0);
    queue_item(KIND_READ, FN_UNUSED, '0, '0);
    queue_item(KIND_SKIP, SKIP_TEST, '0, '0);
    queue_item(KIND_SKIP, FN_UNUSED, '0, '0);
    queue_item(KIND_BAD, RD_ID, 16'hFFFF, 16'hFFFF);
    queue_item(KIND_WRITE, WR_INTERVAL, 16'hFFFE, '0);
    queue_item(KIND_WRITE, WR_CONTROL, 16'h8000, '0);
    queue_item(KIND_TICK, RD_ID, '0, 16'h1234);
    queue_item(KIND_TICK, '0, '0, '0);
    queue_item(KIND_WRITE, WR_VECTOR, 16'h1234, '0);
    queue_item(KIND_TICK, '0, '0, '0);
    queue_item(KIND_TICK, '0, '0, '0);
    queue_item(KIND_SKIP, SKIP_TEST, '0, '0);
    queue_item(KIND_PULSE, PL_ACK_INC0, '0, '0);
    queue_item(KIND_TICK, '0, '0, 16'hFFFF);
    queue_item(KIND_TICK, '0, '0, 16'hFFFF);
    queue_item(KIND_WRITE, WR_CELL, 16'hFFFF, '0);
    queue_item(KIND_TICK, '0, '0, 16'hFFFF);
    queue_item(KIND_TICK, 4'hF, 16'hFFFF, 16'hFFFF);
    queue_item(KIND_PULSE, PL_RESET, '0, '0);
    queue_item(KIND_WRITE, WR_LIGHTS, 16'hFFFF, '0);
    queue_item(KIND_PULSE, FN_UNUSED, '0, '0);
    wait_drained();

    set_device_id(16'hFFFF);
    fill_random(CHUNK);
    wait_drained();

    set_device_id('0);
    fill_random(CHUNK);
    wait_drained();

    // last stretch runs back to back on both sides
    set_device_id(rand_word());
    idle_on = 1'b0;
    fill_random(CHUNK);
    wait_drained();
    repeat (4) @(posedge clk);

    $display("Checked %0d responses over %0d requests in %0d cycles.",
             results_seen, queued, cycles);
    $display("Cell stores %0d, interrupt raises %0d, unsupported codes %0d, mismatches %0d.",
             stores_seen, irq_rises, unsup_seen, errors);
    if (errors == 0 && want_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
